FILE: hw/rtl/assert_macros.svh
// assertion helpers for the nearest segment search block
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NSS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/nss_pkg.sv
// types and fixed widths for the nearest segment search block
// no dependencies
`timescale 1ns / 1ps

package nss_pkg;

    localparam int FIELD_W  = 16;
    localparam int IDX_W    = 10;
    localparam int DIST_W   = 17;
    localparam int D2_W     = 34;
    localparam int MUL_W    = 19;
    localparam int PROD_W   = 38;
    localparam int MAG_W    = 33;
    localparam int SQ_W     = 66;
    localparam int LEN_W    = 32;
    localparam int QUO_W    = 34;
    localparam int STEP_W   = 4;

    localparam logic [D2_W-1:0]   D2_MAX   = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = 17'd92682;

    // sequencer steps in the product phase
    localparam logic [STEP_W-1:0] STEP_DECIDE = 4'd11;
    localparam logic [STEP_W-1:0] STEP_SQ_END = 4'd15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_UPDATE,
        S_SQRT,
        S_EMIT
    } t_state;

endpackage

FILE: hw/rtl/nss_mul.sv
// shared signed multiplier with registered product
// depends on nss_pkg
`timescale 1ns / 1ps

module nss_mul (
    input  logic                                i_clk,
    input  logic signed [nss_pkg::MUL_W-1:0]    i_a,
    input  logic signed [nss_pkg::MUL_W-1:0]    i_b,
    output logic signed [nss_pkg::PROD_W-1:0]   o_prod
);

    logic signed [nss_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: hw/rtl/nss_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// quotient known to fit in QUO_W bits; depends on nss_pkg
`timescale 1ns / 1ps

module nss_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nss_pkg::SQ_W-1:0]    i_dividend,
    input  logic [nss_pkg::LEN_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [nss_pkg::QUO_W-1:0]   o_quot
);

    localparam int QW    = nss_pkg::QUO_W;
    localparam int LW    = nss_pkg::LEN_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [LW-1:0]    r_rem;
    logic [QW-1:0]    r_num;
    logic [LW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [LW:0]      w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // top bits already below the divisor since the quotient fits
            r_rem <= i_dividend[nss_pkg::SQ_W-1:QW];
            r_num <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? LW'(w_trial - {1'b0, r_div}) : w_trial[LW-1:0];
            r_num <= {r_num[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: hw/rtl/nss_sqrt.sv
// bitwise integer square root, one root bit per cycle
// depends on nss_pkg
`timescale 1ns / 1ps

module nss_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nss_pkg::D2_W-1:0]    i_value,
    output logic                        o_done,
    output logic [nss_pkg::DIST_W-1:0]  o_root
);

    localparam int VW    = nss_pkg::D2_W;
    localparam int RW    = nss_pkg::DIST_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic [VW-1:0]    r_val;
    logic [RW:0]      r_rem;
    logic [RW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [RW+2:0]    w_t;
    logic [RW+2:0]    w_trial;
    logic             w_ge;

    assign w_t     = {r_rem, r_val[VW-1:VW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[VW-3:0], 2'b00};
            r_rem  <= w_ge ? (RW+1)'(w_t - w_trial) : w_t[RW:0];
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/nearest_segment_search.sv
// nearest segment search top level: sequencer, run state and output word
// depends on nss_pkg, nss_mul, nss_div, nss_sqrt and assert_macros.svh
`timescale 1ns / 1ps

// Segments stream in one word at a time; the query point is sampled from the
// first word of each run and the word marked last yields the index of the
// nearest segment and its distance. All products go through one 19x19
// multiplier under a step sequencer; when the foot of the perpendicular falls
// inside the segment the 34-step restoring divider runs as well, and the last
// segment adds a 17-step square root. o_in_stall is high from acceptance until
// the segment is fully folded into the running minimum, and on the last segment
// until the result is in the output register. The result sits in an
// output register, so the next run may start while it waits to be taken.

`include "assert_macros.svh"

module nearest_segment_search #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [nss_pkg::FIELD_W-1:0]    i_seg_start_x,
    input  logic signed [nss_pkg::FIELD_W-1:0]    i_seg_start_y,
    input  logic signed [nss_pkg::FIELD_W-1:0]    i_seg_delta_x,
    input  logic signed [nss_pkg::FIELD_W-1:0]    i_seg_delta_y,
    input  logic signed [nss_pkg::FIELD_W-1:0]    i_query_x,
    input  logic signed [nss_pkg::FIELD_W-1:0]    i_query_y,
    input  logic                                  i_last_segment,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [nss_pkg::IDX_W-1:0]             o_nearest_index,
    output logic [nss_pkg::DIST_W-1:0]            o_min_distance
);

    localparam int FW    = nss_pkg::FIELD_W;
    localparam int CW    = (COORD_BITS < FW) ? COORD_BITS : FW;
    localparam int SH    = FW - CW;
    localparam int CNT_W = $clog2(MAX_SEGMENTS);
    localparam int PW    = nss_pkg::PROD_W;
    localparam int MW    = nss_pkg::MUL_W;
    localparam int IW    = nss_pkg::IDX_W;

    nss_pkg::t_state r_state, n_state;

    // run state
    logic                 r_started;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_best_idx;
    logic [nss_pkg::D2_W-1:0] r_best_d2;
    logic signed [FW-1:0] r_qx, r_qy;

    // per-segment working registers
    logic                 r_first, r_last;
    logic [nss_pkg::STEP_W-1:0] r_step;
    logic signed [FW:0]   r_wx, r_wy;
    logic signed [FW-1:0] r_dx, r_dy;
    logic signed [PW-1:0] r_tn, r_len2, r_ds, r_de, r_cr;
    logic [nss_pkg::MAG_W-1:0] r_mag;
    logic [nss_pkg::SQ_W-1:0]  r_sq;
    logic [nss_pkg::D2_W-1:0]  r_d2;

    // output word
    logic                 r_out_valid;
    logic [IW-1:0]        r_out_idx;
    logic [nss_pkg::DIST_W-1:0] r_out_dist;

    logic                 w_accept;
    logic signed [FW-1:0] w_sx, w_sy, w_dx, w_dy, w_qx, w_qy, w_q_x, w_q_y;
    logic signed [FW+1:0] w_ex, w_ey;
    logic signed [MW-1:0] w_a, w_b;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_cr_abs;
    logic                 w_div_start, w_div_done;
    logic [nss_pkg::QUO_W-1:0] w_quot;
    logic                 w_take;
    logic [nss_pkg::D2_W-1:0] w_new_best;
    logic                 w_sqrt_start, w_sqrt_done;
    logic [nss_pkg::DIST_W-1:0] w_root;
    logic                 w_emit;
    logic [CNT_W+IW-1:0]  w_idx_ext;

    // two's complement in the low CW bits of each field
    assign w_sx = (i_seg_start_x <<< SH) >>> SH;
    assign w_sy = (i_seg_start_y <<< SH) >>> SH;
    assign w_dx = (i_seg_delta_x <<< SH) >>> SH;
    assign w_dy = (i_seg_delta_y <<< SH) >>> SH;
    assign w_qx = (i_query_x <<< SH) >>> SH;
    assign w_qy = (i_query_y <<< SH) >>> SH;
    assign w_q_x = r_started ? r_qx : w_qx;
    assign w_q_y = r_started ? r_qy : w_qy;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != nss_pkg::S_IDLE);

    assign w_ex = {r_wx[FW], r_wx} - {{2{r_dx[FW-1]}}, r_dx};
    assign w_ey = {r_wy[FW], r_wy} - {{2{r_dy[FW-1]}}, r_dy};

    // operand select for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_step)
            4'd0: begin
                w_a = MW'(r_wx); w_b = MW'(r_dx);
            end
            4'd1: begin
                w_a = MW'(r_wy); w_b = MW'(r_dy);
            end
            4'd2: begin
                w_a = MW'(r_dx); w_b = MW'(r_dx);
            end
            4'd3: begin
                w_a = MW'(r_dy); w_b = MW'(r_dy);
            end
            4'd4: begin
                w_a = MW'(r_wx); w_b = MW'(r_wx);
            end
            4'd5: begin
                w_a = MW'(r_wy); w_b = MW'(r_wy);
            end
            4'd6: begin
                w_a = MW'(w_ex); w_b = MW'(w_ex);
            end
            4'd7: begin
                w_a = MW'(w_ey); w_b = MW'(w_ey);
            end
            4'd8: begin
                w_a = MW'(r_wx); w_b = MW'(r_dy);
            end
            4'd9: begin
                w_a = MW'(r_wy); w_b = MW'(r_dx);
            end
            // cross magnitude squared in high and low halves
            4'd12: begin
                w_a = {3'b000, r_mag[32:17]}; w_b = {3'b000, r_mag[32:17]};
            end
            4'd13: begin
                w_a = {3'b000, r_mag[32:17]}; w_b = {2'b00, r_mag[16:0]};
            end
            4'd14: begin
                w_a = {2'b00, r_mag[16:0]}; w_b = {2'b00, r_mag[16:0]};
            end
            default: begin
                w_a = '0; w_b = '0;
            end
        endcase
    end

    nss_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign w_div_start = (r_state == nss_pkg::S_CALC) && (r_step == nss_pkg::STEP_SQ_END);

    nss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sq + {32'd0, w_prod[33:0]}),
        .i_divisor  (r_len2[nss_pkg::LEN_W-1:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_take       = r_first || (r_d2 < r_best_d2);
    assign w_new_best   = w_take ? r_d2 : r_best_d2;
    assign w_sqrt_start = (r_state == nss_pkg::S_UPDATE) && r_last;

    nss_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_new_best),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign w_emit    = (r_state == nss_pkg::S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_cr_abs  = r_cr[PW-1] ? -r_cr : r_cr;
    assign w_idx_ext = {{IW{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nss_pkg::S_IDLE: begin
                if (w_accept) n_state = nss_pkg::S_CALC;
            end
            nss_pkg::S_CALC: begin
                if (r_step == nss_pkg::STEP_DECIDE) begin
                    if (r_tn <= 0 || r_tn >= r_len2) n_state = nss_pkg::S_UPDATE;
                end else if (r_step == nss_pkg::STEP_SQ_END) begin
                    n_state = nss_pkg::S_DIV;
                end
            end
            nss_pkg::S_DIV: begin
                if (w_div_done) n_state = nss_pkg::S_UPDATE;
            end
            nss_pkg::S_UPDATE: begin
                n_state = r_last ? nss_pkg::S_SQRT : nss_pkg::S_IDLE;
            end
            nss_pkg::S_SQRT: begin
                if (w_sqrt_done) n_state = nss_pkg::S_EMIT;
            end
            nss_pkg::S_EMIT: begin
                if (w_emit) n_state = nss_pkg::S_IDLE;
            end
            default: n_state = nss_pkg::S_IDLE;
        endcase
    end

    // control: run state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_cnt       <= '0;
            r_best_idx  <= '0;
            r_best_d2   <= nss_pkg::D2_MAX;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_accept) begin
                r_started <= 1'b1;
                r_step    <= '0;
            end else if (r_state == nss_pkg::S_CALC) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == nss_pkg::S_UPDATE) begin
                r_best_d2 <= w_new_best;
                if (w_take) r_best_idx <= r_cnt;
                r_cnt <= (r_cnt == CNT_W'(MAX_SEGMENTS - 1)) ? '0 : r_cnt + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_started   <= 1'b0;
                r_cnt       <= '0;
                r_best_idx  <= '0;
                r_best_d2   <= nss_pkg::D2_MAX;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= !r_started;
            r_last  <= i_last_segment;
            r_qx    <= w_q_x;
            r_qy    <= w_q_y;
            r_wx    <= {w_q_x[FW-1], w_q_x} - {w_sx[FW-1], w_sx};
            r_wy    <= {w_q_y[FW-1], w_q_y} - {w_sy[FW-1], w_sy};
            r_dx    <= w_dx;
            r_dy    <= w_dy;
        end
        if (r_state == nss_pkg::S_CALC) begin
            case (r_step)
                4'd1:  r_tn   <= w_prod;
                4'd2:  r_tn   <= r_tn + w_prod;
                4'd3:  r_len2 <= w_prod;
                4'd4:  r_len2 <= r_len2 + w_prod;
                4'd5:  r_ds   <= w_prod;
                4'd6:  r_ds   <= r_ds + w_prod;
                4'd7:  r_de   <= w_prod;
                4'd8:  r_de   <= r_de + w_prod;
                4'd9:  r_cr   <= w_prod;
                4'd10: r_cr   <= r_cr - w_prod;
                4'd11: begin
                    r_mag <= w_cr_abs[nss_pkg::MAG_W-1:0];
                    if (r_tn <= 0) begin
                        r_d2 <= (r_ds[PW-1:34] != '0) ? nss_pkg::D2_MAX : r_ds[33:0];
                    end else begin
                        r_d2 <= (r_de[PW-1:34] != '0) ? nss_pkg::D2_MAX : r_de[33:0];
                    end
                end
                4'd13: r_sq <= {w_prod[31:0], 34'd0};
                4'd14: r_sq <= r_sq + {14'd0, w_prod[33:0], 18'd0};
                default: r_sq <= r_sq;
            endcase
        end
        if (w_div_done) begin
            r_d2 <= w_quot;
        end
        if (w_emit) begin
            r_out_idx  <= w_idx_ext[IW-1:0];
            r_out_dist <= (w_root > nss_pkg::DIST_MAX) ? nss_pkg::DIST_MAX : w_root;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_idx;
    assign o_min_distance  = r_out_dist;

    `NSS_ASSERT_NEXT(a_busy_after_accept, w_accept, o_in_stall, "accepted word not held busy")
    `NSS_ASSERT_IMPL(a_div_nonzero, w_div_start, r_len2 > 0, "divider started with zero length")
    `NSS_ASSERT_IMPL(a_idle_run_clear, !r_started, r_best_d2 == nss_pkg::D2_MAX && r_cnt == '0, "run state not cleared between runs")

endmodule

FILE: test/nss_checker.sv
// result checker for nearest_segment_search: computes the expected nearest index
// and distance for each run from the accepted input words, compares the output words
`timescale 1ns / 1ps

module nss_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic signed [nss_pkg::FIELD_W-1:0] i_seg_start_x,
    input  logic signed [nss_pkg::FIELD_W-1:0] i_seg_start_y,
    input  logic signed [nss_pkg::FIELD_W-1:0] i_seg_delta_x,
    input  logic signed [nss_pkg::FIELD_W-1:0] i_seg_delta_y,
    input  logic signed [nss_pkg::FIELD_W-1:0] i_query_x,
    input  logic signed [nss_pkg::FIELD_W-1:0] i_query_y,
    input  logic                               i_last_segment,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [nss_pkg::IDX_W-1:0]          i_nearest_index,
    input  logic [nss_pkg::DIST_W-1:0]         i_min_distance,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_results_seen
);

    typedef struct packed {
        logic [nss_pkg::IDX_W-1:0]  index;
        logic [nss_pkg::DIST_W-1:0] distance;
    } t_nearest;

    t_nearest nearest_q[$];

    logic [nss_pkg::IDX_W-1:0] run_position;
    logic [nss_pkg::IDX_W-1:0] run_best_index;
    logic [nss_pkg::D2_W-1:0]  run_best_d2;
    longint                    anchor_x, anchor_y;
    bit                        in_run;

    function automatic logic [nss_pkg::D2_W-1:0] clamp_d2(logic [127:0] v);
        return (v > 128'(nss_pkg::D2_MAX)) ? nss_pkg::D2_MAX : v[nss_pkg::D2_W-1:0];
    endfunction

    // squared distance from the held query point to one segment
    function automatic logic [nss_pkg::D2_W-1:0] segment_d2(longint qx, longint qy,
                                                            longint sx, longint sy,
                                                            longint dx, longint dy);
        longint       wx, wy, proj, len2, ex, ey, crs;
        logic [127:0] num;
        wx   = qx - sx;
        wy   = qy - sy;
        proj = wx * dx + wy * dy;
        len2 = dx * dx + dy * dy;
        if (proj <= 0)
            return clamp_d2(128'(wx * wx) + 128'(wy * wy));
        if (proj >= len2) begin
            ex = wx - dx;
            ey = wy - dy;
            return clamp_d2(128'(ex * ex) + 128'(ey * ey));
        end
        crs = wx * dy - wy * dx;
        if (crs < 0) crs = -crs;
        num = 128'(crs) * 128'(crs);
        return clamp_d2(num / 128'(len2));
    endfunction

    function automatic logic [nss_pkg::DIST_W-1:0] distance_of(logic [nss_pkg::D2_W-1:0] d2);
        logic [nss_pkg::D2_W-1:0] r;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            if ((64'(r | (34'd1 << b)) * 64'(r | (34'd1 << b))) <= 64'(d2))
                r = r | (34'd1 << b);
        end
        return (r > 34'(nss_pkg::DIST_MAX)) ? nss_pkg::DIST_MAX : r[nss_pkg::DIST_W-1:0];
    endfunction

    assign o_pending = nearest_q.size();

    always @(posedge i_clk) begin
        logic [nss_pkg::D2_W-1:0] d2;
        t_nearest                 want;
        int                       errs;
        if (!i_rst_n) begin
            in_run         <= 1'b0;
            run_position   <= '0;
            run_best_index <= '0;
            run_best_d2    <= nss_pkg::D2_MAX;
            o_fail_count   <= 0;
            o_results_seen <= 0;
        end else begin
            errs = 0;
            if (i_in_valid && !i_in_stall) begin
                if (!in_run) begin
                    anchor_x = i_query_x;
                    anchor_y = i_query_y;
                end
                d2 = segment_d2(anchor_x, anchor_y, i_seg_start_x, i_seg_start_y,
                                i_seg_delta_x, i_seg_delta_y);
                want.index    = run_best_index;
                want.distance = 0;
                if (!in_run || d2 < run_best_d2) begin
                    run_best_d2    <= d2;
                    run_best_index <= run_position;
                    want.index     = run_position;
                end else begin
                    d2 = run_best_d2;
                end
                if (i_last_segment) begin
                    want.distance = distance_of(d2);
                    nearest_q.push_back(want);
                    in_run       <= 1'b0;
                    run_position <= '0;
                end else begin
                    in_run       <= 1'b1;
                    run_position <= run_position + 1'b1;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (nearest_q.size() == 0) begin
                    $error("unexpected output word: index %0d distance %0d",
                           i_nearest_index, i_min_distance);
                    errs++;
                end else begin
                    want = nearest_q.pop_front();
                    if (i_nearest_index !== want.index) begin
                        $error("nearest_index: expected %0d, got %0d", want.index,
                               i_nearest_index);
                        errs++;
                    end
                    if (i_min_distance !== want.distance) begin
                        $error("min_distance: expected %0d, got %0d", want.distance,
                               i_min_distance);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

FILE: test/tb_nearest_segment_search.sv
// stimulus and verdict for nearest_segment_search: directed and random runs of
// segments under varying idle rates; depends on nss_pkg and nss_checker
`timescale 1ns / 1ps

module tb_nearest_segment_search;

    localparam int FW = nss_pkg::FIELD_W;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    logic signed [FW-1:0] i_seg_start_x, i_seg_start_y, i_seg_delta_x, i_seg_delta_y;
    logic signed [FW-1:0] i_query_x, i_query_y;
    logic i_last_segment;
    logic [nss_pkg::IDX_W-1:0]  o_nearest_index;
    logic [nss_pkg::DIST_W-1:0] o_min_distance;
    int fail_count, pending, results_seen;
    int out_idle_pct, words_sent, cycle_count;
    bit hold_active;

    nearest_segment_search u_dut (.*);

    nss_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall),
        .i_seg_start_x, .i_seg_start_y, .i_seg_delta_x, .i_seg_delta_y,
        .i_query_x, .i_query_y, .i_last_segment,
        .i_out_valid(o_out_valid), .i_out_stall, .i_nearest_index(o_nearest_index),
        .i_min_distance(o_min_distance), .o_fail_count(fail_count),
        .o_pending(pending), .o_results_seen(results_seen)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver stall: a forced hold-off wins, otherwise random at the current rate
    always @(negedge i_clk) begin
        i_out_stall <= hold_active || ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("tb_nearest_segment_search: errors");
            $finish;
        end
    end

    // long receiver hold-off, counted in its own process
    task automatic hold_off(int cycles);
        hold_active = 1'b1;
        repeat (cycles) @(negedge i_clk);
        hold_active = 1'b0;
    endtask

    function automatic logic [FW-1:0] pick_coord(int mode);
        case (mode)
            0: return FW'($urandom);
            1: return FW'($signed($urandom_range(400)) - 200);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return FW'($signed($urandom_range(8000)) - 4000);
        endcase
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(logic [FW-1:0] sx, logic [FW-1:0] sy,
                             logic [FW-1:0] dx, logic [FW-1:0] dy,
                             logic [FW-1:0] qx, logic [FW-1:0] qy,
                             logic last, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_seg_start_x  <= sx;
        i_seg_start_y  <= sy;
        i_seg_delta_x  <= dx;
        i_seg_delta_y  <= dy;
        i_query_x      <= qx;
        i_query_y      <= qy;
        i_last_segment <= last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic random_run(int idle_pct);
        int len, mode;
        len  = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        mode = $urandom_range(3);
        for (int k = 0; k < len; k++)
            send_word(pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode),
                      pick_coord(mode), pick_coord(mode), k == len - 1, idle_pct);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_stall = 1'b0; i_last_segment = 1'b0;
        i_seg_start_x = '0; i_seg_start_y = '0; i_seg_delta_x = '0; i_seg_delta_y = '0;
        i_query_x = '0; i_query_y = '0;
        out_idle_pct = 0; hold_active = 1'b0; words_sent = 0; cycle_count = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: foot before start, beyond end, inside, zero length, extremes, ties
        send_word(16'sd0, 16'sd0, 16'sd160, 16'sd0, -16'sd32, 16'sd48, 1'b0, 0);
        send_word(16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd0, 1'b0, 0);
        send_word(16'sd0, 16'sd80, 16'sd64, 16'sd0, 16'sd0, 16'sd0, 1'b0, 0);
        send_word(-16'sd32, 16'sd48, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 0);
        send_word(16'sd0, -16'sd80, 16'sd0, 16'sd160, 16'sd48, 16'sd0, 1'b1, 0);
        send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, 0);
        send_word(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 0);
        send_word(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0, 16'h0, 1'b1, 0);
        send_word(16'h7fff, 16'h7fff, 16'h0, 16'h0, 16'h8000, 16'h8000, 1'b1, 0);
        send_word(16'sd10, 16'sd10, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b0, 0);
        send_word(16'sd10, 16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 0);
        send_word(16'sd5, 16'sd0, 16'sd0, 16'sd7, 16'sd0, 16'sd3, 1'b1, 0);
        send_word(16'sd0, 16'sd0, 16'sd3, 16'sd5, 16'sd1, 16'sd2, 1'b1, 0);

        // receiver holds off while short runs keep coming, so the block fills up
        fork
            hold_off(3000);
        join_none
        for (int k = 0; k < 12; k++)
            send_word(pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1),
                      pick_coord(1), pick_coord(1), k % 3 == 2, 0);
        drain();

        // segment position wraps past the index width
        for (int k = 0; k < 1030; k++)
            send_word(pick_coord(3), pick_coord(3), pick_coord(3), pick_coord(3),
                      pick_coord(3), pick_coord(3), k == 1029, 0);
        drain();

        out_idle_pct = 74;
        while (words_sent < 1270) random_run(23);
        drain();
        out_idle_pct = 23;
        while (words_sent < 1480) random_run(74);
        drain();
        out_idle_pct = 0;
        while (words_sent < 1700) random_run(0);
        drain();

        $display("covered %0d segment words and %0d nearest results", words_sent,
                 results_seen);
        $display("perpendicular, endpoint, degenerate, extreme and wrapped runs driven");
        if (fail_count == 0)
            $display("tb_nearest_segment_search: clean");
        else
            $display("tb_nearest_segment_search: errors");
        $finish;
    end

endmodule
